FILE: rtl/core/spf_pkg.sv
// Package for the smallest prime factor sieve factorizer.
// Holds the widths, status codes, op codes, emit kinds, controller states and the command/status structs.
// No dependencies.
package spf_pkg;

  localparam int VW = 20;
  localparam int EW = 5;
  localparam int SW = 2;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVER      = 2'd1,
    ST_NOT_BUILT = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    OP_BUILD  = 1'b0,
    OP_FACTOR = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    EM_EMPTY,
    EM_OVER,
    EM_NOT_BUILT,
    EM_PRIME,
    EM_FINAL
  } emit_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLR,
    S_I_RD,
    S_I_CHK,
    S_J_RD,
    S_J_WR,
    S_BDONE,
    S_CHK,
    S_F_RD,
    S_F_LOOK,
    S_F_DIVW,
    S_F_FIN
  } state_t;

  typedef struct packed {
    logic  ld_in;
    logic  bld_init;
    logic  clr_wr;
    logic  i_init;
    logic  rd_i;
    logic  mark_i;
    logic  i_inc;
    logic  rd_j;
    logic  wr_j;
    logic  j_inc;
    logic  set_built;
    logic  rd_cur;
    logic  take_p;
    logic  div_start;
    logic  div_take;
    logic  emit;
    emit_t emit_kind;
  } cmd_t;

  typedef struct packed {
    logic built;
    logic v_small;
    logic v_over;
    logic clr_last;
    logic i_done;
    logic j_done;
    logic rd_zero;
    logic p_diff;
    logic div_done;
    logic quot_one;
    logic out_free;
  } stat_t;

endpackage

FILE: rtl/core/spf_if.sv
// Channel interfaces: input item, result item and configuration write.
// Depends on spf_pkg for field widths.
interface spf_in_if;
  import spf_pkg::*;
  logic          valid;
  logic          ready;
  logic          op;
  logic [VW-1:0] value;
  modport source (output valid, op, value, input ready);
  modport sink   (input valid, op, value, output ready);
endinterface

interface spf_out_if;
  import spf_pkg::*;
  logic          valid;
  logic          ready;
  logic [VW-1:0] prime;
  logic [EW-1:0] exponent;
  logic [SW-1:0] status;
  logic          last;
  modport source (output valid, prime, exponent, status, last, input ready);
  modport sink   (input valid, prime, exponent, status, last, output ready);
endinterface

interface spf_cfg_if;
  import spf_pkg::*;
  logic          valid;
  logic          ready;
  logic [VW-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

FILE: rtl/core/smallest_prime_factor_sieve_factorizer.sv
// Smallest prime factor sieve factorizer, top level.
// Depends on spf_pkg, spf_if, spf_ctrl, spf_dp.
// One item at a time. A build clears table entries 0..limit, then walks the sieve
// with a single-port table memory: a read state and a check state per candidate and
// a read state and a write state per multiple visited, then gives one done result.
// A factor item is checked first; each prime power step then does one table read, a
// bit-serial division and, unless the quotient is one, a take of it. The result
// register lets the last result wait while a new item enters.
module smallest_prime_factor_sieve_factorizer #(
  parameter int MAX_NUMBER = 1048576
) (
  input logic        clk,
  input logic        rst_n,
  spf_in_if.sink     in_ch,
  spf_out_if.source  out_ch,
  spf_cfg_if.sink    cfg_ch
);
  import spf_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  spf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.op),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  spf_dp #(
    .MAX_NUMBER (MAX_NUMBER)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_op        (in_ch.op),
    .in_value     (in_ch.value),
    .cfg_valid    (cfg_ch.valid),
    .cfg_ready    (cfg_ch.ready),
    .cfg_data     (cfg_ch.data),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_prime    (out_ch.prime),
    .out_exponent (out_ch.exponent),
    .out_status   (out_ch.status),
    .out_last     (out_ch.last)
  );

endmodule

FILE: rtl/core/spf_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on spf_pkg for the value width.
module spf_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [spf_pkg::VW-1:0] dividend,
  input  logic [spf_pkg::VW-1:0] divisor,
  output logic                   done,
  output logic [spf_pkg::VW-1:0] quot
);
  import spf_pkg::*;

  localparam int CW = $clog2(VW + 1);

  logic          busy_r;
  logic [CW-1:0] cnt_r;
  logic [VW-1:0] q_r;
  logic [VW-1:0] d_r;
  logic [VW:0]   rem_r;
  logic [VW:0]   sh;
  logic          ge;

  assign sh   = {rem_r[VW-1:0], q_r[VW-1]};
  assign ge   = sh >= {1'b0, d_r};
  assign done = !busy_r;
  assign quot = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(VW);
    end else if (busy_r) begin
      cnt_r  <= cnt_r - 1'b1;
      busy_r <= (cnt_r != CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      d_r   <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? (sh - {1'b0, d_r}) : sh;
      q_r   <= {q_r[VW-2:0], ge};
    end
  end

endmodule

FILE: rtl/core/spf_dp.sv
// Datapath: table memory, sieve counters, factor registers, divider, result register.
// Depends on spf_pkg and spf_div.
module spf_dp #(
  parameter int MAX_NUMBER = 1048576
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  spf_pkg::cmd_t          cmd,
  output spf_pkg::stat_t         stat,
  input  logic                   in_op,
  input  logic [spf_pkg::VW-1:0] in_value,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [spf_pkg::VW-1:0] cfg_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [spf_pkg::VW-1:0] out_prime,
  output logic [spf_pkg::EW-1:0] out_exponent,
  output logic [spf_pkg::SW-1:0] out_status,
  output logic                   out_last
);
  import spf_pkg::*;

  localparam int AW   = $clog2(MAX_NUMBER);
  localparam int CAPI = (MAX_NUMBER - 1 > 1048575) ? 1048575 : MAX_NUMBER - 1;
  localparam logic [VW-1:0] CAP = VW'(CAPI);

  logic [VW-1:0] mem [MAX_NUMBER];

  logic [VW-1:0] sieve_limit_r;
  logic [VW-1:0] built_limit_r;
  logic          built_r;
  logic [VW-1:0] value_r;
  logic [VW-1:0] cur_r;
  logic [VW-1:0] prime_r;
  logic [EW-1:0] exp_r;
  logic [VW-1:0] addr_r;
  logic [VW:0]   i_r;
  logic [VW:0]   j_r;
  logic [VW-1:0] rd_data_r;

  logic          out_valid_r;
  logic [VW-1:0] out_prime_r;
  logic [EW-1:0] out_exp_r;
  logic [SW-1:0] out_status_r;
  logic          out_last_r;

  logic [VW-1:0] cfg_cap;
  logic [VW-1:0] fac_lim;
  logic          we;
  logic [AW-1:0] wa;
  logic [VW-1:0] wd;
  logic          re;
  logic [AW-1:0] ra;
  logic          div_done;
  logic [VW-1:0] quot;

  spf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (cur_r),
    .divisor  (rd_data_r),
    .done     (div_done),
    .quot     (quot)
  );

  assign cfg_ready = 1'b1;
  assign cfg_cap   = (sieve_limit_r < CAP) ? sieve_limit_r : CAP;
  assign fac_lim   = (built_limit_r < cfg_cap) ? built_limit_r : cfg_cap;

  always_comb begin
    stat.built    = built_r;
    stat.v_small  = value_r < VW'(2);
    stat.v_over   = value_r > fac_lim;
    stat.clr_last = addr_r == built_limit_r;
    stat.i_done   = i_r > {1'b0, built_limit_r};
    stat.j_done   = j_r > {1'b0, built_limit_r};
    stat.rd_zero  = rd_data_r == '0;
    stat.p_diff   = (prime_r != '0) && (rd_data_r != prime_r);
    stat.div_done = div_done;
    stat.quot_one = quot == VW'(1);
    stat.out_free = !out_valid_r || out_ready;
  end

  always_comb begin
    we = 1'b0;
    wa = AW'(addr_r);
    wd = '0;
    if (cmd.mark_i) begin
      we = 1'b1;
      wa = AW'(i_r);
      wd = i_r[VW-1:0];
    end else if (cmd.wr_j) begin
      we = rd_data_r == '0;
      wa = AW'(j_r);
      wd = i_r[VW-1:0];
    end else if (cmd.clr_wr) begin
      we = 1'b1;
    end
    re = cmd.rd_i || cmd.rd_j || cmd.rd_cur;
    if (cmd.rd_j) begin
      ra = AW'(j_r);
    end else if (cmd.rd_cur) begin
      ra = AW'(cur_r);
    end else begin
      ra = AW'(i_r);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_data_r <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sieve_limit_r <= '1;
      built_limit_r <= '0;
      built_r       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        sieve_limit_r <= cfg_data;
      end
      if (cmd.bld_init) begin
        built_limit_r <= cfg_cap;
      end
      if (cmd.set_built) begin
        built_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      value_r <= in_op ? in_value : '0;
      cur_r   <= in_value;
      prime_r <= '0;
      exp_r   <= '0;
    end
    if (cmd.bld_init) begin
      addr_r <= '0;
    end else if (cmd.clr_wr) begin
      addr_r <= addr_r + 1'b1;
    end
    if (cmd.i_init) begin
      i_r <= (VW + 1)'(2);
    end else if (cmd.i_inc) begin
      i_r <= i_r + 1'b1;
    end
    if (cmd.mark_i) begin
      j_r <= i_r + i_r;
    end else if (cmd.j_inc) begin
      j_r <= j_r + i_r;
    end
    if (cmd.take_p) begin
      prime_r <= rd_data_r;
      if (rd_data_r != prime_r) begin
        exp_r <= '0;
      end
    end
    if (cmd.div_take) begin
      cur_r <= quot;
      exp_r <= exp_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      unique case (cmd.emit_kind)
        EM_OVER: begin
          out_prime_r  <= '0;
          out_exp_r    <= '0;
          out_status_r <= ST_OVER;
          out_last_r   <= 1'b1;
        end
        EM_NOT_BUILT: begin
          out_prime_r  <= '0;
          out_exp_r    <= '0;
          out_status_r <= ST_NOT_BUILT;
          out_last_r   <= 1'b1;
        end
        EM_PRIME: begin
          out_prime_r  <= prime_r;
          out_exp_r    <= exp_r;
          out_status_r <= ST_OK;
          out_last_r   <= 1'b0;
        end
        EM_FINAL: begin
          out_prime_r  <= prime_r;
          out_exp_r    <= exp_r + 1'b1;
          out_status_r <= ST_OK;
          out_last_r   <= 1'b1;
        end
        default: begin
          out_prime_r  <= '0;
          out_exp_r    <= '0;
          out_status_r <= ST_OK;
          out_last_r   <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_prime    = out_prime_r;
  assign out_exponent = out_exp_r;
  assign out_status   = out_status_r;
  assign out_last     = out_last_r;

endmodule

FILE: rtl/core/spf_ctrl.sv
// Controller state machine for build and factor sequences.
// Depends on spf_pkg.
module spf_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_op,
  output logic           in_ready,
  input  spf_pkg::stat_t stat,
  output spf_pkg::cmd_t  cmd
);
  import spf_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.emit_kind = EM_EMPTY;
    in_ready      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.ld_in = 1'b1;
          if (in_op == OP_BUILD) begin
            cmd.bld_init = 1'b1;
            state_nxt    = S_CLR;
          end else begin
            state_nxt = S_CHK;
          end
        end
      end
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) begin
          cmd.i_init = 1'b1;
          state_nxt  = S_I_RD;
        end
      end
      S_I_RD: begin
        if (stat.i_done) begin
          state_nxt = S_BDONE;
        end else begin
          cmd.rd_i  = 1'b1;
          state_nxt = S_I_CHK;
        end
      end
      S_I_CHK: begin
        if (stat.rd_zero) begin
          cmd.mark_i = 1'b1;
          state_nxt  = S_J_RD;
        end else begin
          cmd.i_inc = 1'b1;
          state_nxt = S_I_RD;
        end
      end
      S_J_RD: begin
        if (stat.j_done) begin
          cmd.i_inc = 1'b1;
          state_nxt = S_I_RD;
        end else begin
          cmd.rd_j  = 1'b1;
          state_nxt = S_J_WR;
        end
      end
      S_J_WR: begin
        cmd.wr_j  = 1'b1;
        cmd.j_inc = 1'b1;
        state_nxt = S_J_RD;
      end
      S_BDONE: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = EM_EMPTY;
          cmd.set_built = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_CHK: begin
        if (!stat.built || stat.v_small || stat.v_over) begin
          if (stat.out_free) begin
            cmd.emit = 1'b1;
            if (!stat.built) begin
              cmd.emit_kind = EM_NOT_BUILT;
            end else if (stat.v_small) begin
              cmd.emit_kind = EM_EMPTY;
            end else begin
              cmd.emit_kind = EM_OVER;
            end
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_F_RD;
        end
      end
      S_F_RD: begin
        cmd.rd_cur = 1'b1;
        state_nxt  = S_F_LOOK;
      end
      S_F_LOOK: begin
        if (!stat.p_diff || stat.out_free) begin
          cmd.emit      = stat.p_diff;
          cmd.emit_kind = EM_PRIME;
          cmd.take_p    = 1'b1;
          cmd.div_start = 1'b1;
          state_nxt     = S_F_DIVW;
        end
      end
      S_F_DIVW: begin
        if (stat.div_done) begin
          if (stat.quot_one) begin
            state_nxt = S_F_FIN;
          end else begin
            cmd.div_take = 1'b1;
            state_nxt    = S_F_RD;
          end
        end
      end
      S_F_FIN: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = EM_FINAL;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

FILE: rtl/core/spf_chk.sv
// Port-level checks for the sieve factorizer, bound to the top level.
// Depends on spf_pkg and smallest_prime_factor_sieve_factorizer.
module spf_chk (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [spf_pkg::VW-1:0] out_prime,
  input logic [spf_pkg::EW-1:0] out_exponent,
  input logic [spf_pkg::SW-1:0] out_status,
  input logic                   out_last
);
  import spf_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_prime) && $stable(out_last))
    else $error("result dropped or changed while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while busy");

  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_prime == '0 && out_exponent == '0 && out_last)
    else $error("error result with payload");

  a_mid_prime: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_status == ST_OK && out_prime >= VW'(2))
    else $error("non-final result without a prime");

  a_exp_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_prime != '0 |-> out_exponent != '0)
    else $error("prime with zero exponent");

endmodule

bind smallest_prime_factor_sieve_factorizer spf_chk u_spf_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_prime    (out_ch.prime),
  .out_exponent (out_ch.exponent),
  .out_status   (out_ch.status),
  .out_last     (out_ch.last)
);
